FILE: rtl/core/qnl_pkg.sv
// ----------------------------------------------------------------------------
// qnl_pkg
// Shared widths, pipeline stage map and the stage payload type of the
// quaternion nlerp pipeline.
// ----------------------------------------------------------------------------
package qnl_pkg;

    localparam int LANES      = 4;
    localparam int COMP_W     = 16;
    localparam int PROD_W     = 32;
    localparam int DOT_W      = 34;
    localparam int DIFF_W     = 18;
    localparam int BMUL_W     = 34;
    localparam int BLEND_W    = 19;
    localparam int MAG_W      = 18;
    localparam int SQ_W       = 35;
    localparam int SUM_W      = 38;
    localparam int ROOT_W     = SUM_W / 2;
    localparam int SREM_W     = ROOT_W + 2;
    localparam int QUO_W      = 16;
    localparam int FRAC_BITS  = 14;

    // Stage map: every stage is one register.
    localparam int ST_IN      = 0;
    localparam int ST_PROD    = 1;
    localparam int ST_DIFF    = 2;
    localparam int ST_BMUL    = 3;
    localparam int ST_BLEND   = 4;
    localparam int ST_SQ      = 5;
    localparam int ST_SUM     = 6;
    localparam int ST_SQRT0   = 7;
    localparam int ST_DIVSET  = ST_SQRT0 + ROOT_W;
    localparam int ST_DIV0    = ST_DIVSET + 1;
    localparam int ST_OUT     = ST_DIV0 + QUO_W;
    localparam int NUM_STAGES = ST_OUT + 1;

    typedef struct packed {
        logic                                  sp;
        logic [COMP_W-1:0]                     t;
        logic [LANES-1:0][COMP_W-1:0]          p;
        logic [LANES-1:0][COMP_W-1:0]          q;
        logic [LANES-1:0][PROD_W-1:0]          pq;
        logic [LANES-1:0][DIFF_W-1:0]          d;
        logic [LANES-1:0][BMUL_W-1:0]          m;
        logic [LANES-1:0][BLEND_W-1:0]         l;
        logic [LANES-1:0][SQ_W-1:0]            lsq;
        logic [SUM_W-1:0]                      sqv;
        logic [SREM_W-1:0]                     srem;
        logic [ROOT_W-1:0]                     root;
        logic [LANES-1:0][ROOT_W-1:0]          drem;
        logic [LANES-1:0][QUO_W-1:0]           dlow;
        logic [LANES-1:0][QUO_W-1:0]           quo;
        logic [LANES-1:0]                      neg;
        logic [LANES-1:0][COMP_W-1:0]          r;
        logic                                  zn;
    } stage_t;

endpackage

FILE: rtl/core/quaternion_nlerp.sv
// Quaternion nlerp: one item per clock while the output is not stalled. A result
// reaches the output after its input beat is accepted, having passed
// qnl_pkg::NUM_STAGES (44) registers. The depth is set by the square root, one
// result bit per stage (19 stages), and by the four parallel dividers, one
// quotient bit per stage (16 stages). Each stage advances when it is empty or
// its successor advances, so bubbles close up and input beats keep flowing
// while a result waits on the output, until every stage holds a beat.
// ----------------------------------------------------------------------------
// quaternion_nlerp
// Normalized linear interpolation of two Q2.14 quaternions with optional
// shortest-path flip, integer square root and per-component division.
// ----------------------------------------------------------------------------
module quaternion_nlerp (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_shortest_path,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_p_w,
    input  logic [15:0] s_p_x,
    input  logic [15:0] s_p_y,
    input  logic [15:0] s_p_z,
    input  logic [15:0] s_q_w,
    input  logic [15:0] s_q_x,
    input  logic [15:0] s_q_y,
    input  logic [15:0] s_q_z,
    input  logic [15:0] s_blend,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_r_w,
    output logic [15:0] m_r_x,
    output logic [15:0] m_r_y,
    output logic [15:0] m_r_z,
    output logic        m_zero_norm
);

    localparam int N = qnl_pkg::NUM_STAGES;
    localparam int L = qnl_pkg::LANES;

    logic shortest_path_reg;

    qnl_pkg::stage_t stage_reg  [N];
    qnl_pkg::stage_t stage_next [N];
    logic [N-1:0]    valid_reg;
    logic [N-1:0]    adv;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shortest_path_reg <= 1'b1;
        end else if (cfg_valid) begin
            shortest_path_reg <= cfg_shortest_path;
        end
    end

    // Stage enables ripple back from the output register.
    always_comb begin
        adv[N-1] = !valid_reg[N-1] || m_ready;
        for (int k = N - 2; k >= 0; k--) begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    assign s_ready = adv[0];

    always_comb begin
        stage_next[0]      = stage_reg[0];
        stage_next[0].sp   = shortest_path_reg;
        stage_next[0].t    = s_blend;
        stage_next[0].p[0] = s_p_w;
        stage_next[0].p[1] = s_p_x;
        stage_next[0].p[2] = s_p_y;
        stage_next[0].p[3] = s_p_z;
        stage_next[0].q[0] = s_q_w;
        stage_next[0].q[1] = s_q_x;
        stage_next[0].q[2] = s_q_y;
        stage_next[0].q[3] = s_q_z;
    end

    for (genvar k = 1; k < N; k++) begin : g_stage
        if (k == qnl_pkg::ST_PROD) begin : g_prod
            always_comb begin
                stage_next[k] = stage_reg[k-1];
                for (int i = 0; i < L; i++) begin
                    stage_next[k].pq[i] = $signed(stage_reg[k-1].p[i])
                                        * $signed(stage_reg[k-1].q[i]);
                end
            end
        end else if (k == qnl_pkg::ST_DIFF) begin : g_diff
            always_comb begin
                logic signed [qnl_pkg::DOT_W-1:0] dot;
                logic signed [16:0]               qn;
                logic                             flip;
                stage_next[k] = stage_reg[k-1];
                dot = '0;
                for (int i = 0; i < L; i++) begin
                    dot = dot + qnl_pkg::DOT_W'($signed(stage_reg[k-1].pq[i]));
                end
                // A dot product of exactly zero leaves q as it is.
                flip = stage_reg[k-1].sp && dot[qnl_pkg::DOT_W-1];
                for (int i = 0; i < L; i++) begin
                    qn = 17'($signed(stage_reg[k-1].q[i]));
                    if (flip) begin
                        qn = -qn;
                    end
                    stage_next[k].d[i] = 18'($signed(qn))
                                       - 18'($signed(stage_reg[k-1].p[i]));
                end
            end
        end else if (k == qnl_pkg::ST_BMUL) begin : g_bmul
            always_comb begin
                logic signed [34:0] prod;
                stage_next[k] = stage_reg[k-1];
                for (int i = 0; i < L; i++) begin
                    prod = $signed({1'b0, stage_reg[k-1].t})
                         * $signed(stage_reg[k-1].d[i]);
                    stage_next[k].m[i] = prod[qnl_pkg::BMUL_W-1:0];
                end
            end
        end else if (k == qnl_pkg::ST_BLEND) begin : g_blend
            always_comb begin
                logic signed [qnl_pkg::BMUL_W-1:0] sh;
                stage_next[k] = stage_reg[k-1];
                for (int i = 0; i < L; i++) begin
                    // An arithmetic shift is the floor division by 2^15.
                    sh = $signed(stage_reg[k-1].m[i]) >>> 15;
                    stage_next[k].l[i] = 19'($signed(stage_reg[k-1].p[i]))
                                       + sh[qnl_pkg::BLEND_W-1:0];
                end
            end
        end else if (k == qnl_pkg::ST_SQ) begin : g_sq
            always_comb begin
                logic signed [37:0] sq;
                stage_next[k] = stage_reg[k-1];
                for (int i = 0; i < L; i++) begin
                    sq = $signed(stage_reg[k-1].l[i]) * $signed(stage_reg[k-1].l[i]);
                    stage_next[k].lsq[i] = sq[qnl_pkg::SQ_W-1:0];
                end
            end
        end else if (k == qnl_pkg::ST_SUM) begin : g_sum
            always_comb begin
                stage_next[k]      = stage_reg[k-1];
                stage_next[k].sqv  = '0;
                for (int i = 0; i < L; i++) begin
                    stage_next[k].sqv = stage_next[k].sqv
                                      + qnl_pkg::SUM_W'(stage_reg[k-1].lsq[i]);
                end
                stage_next[k].srem = '0;
                stage_next[k].root = '0;
            end
        end else if (k < qnl_pkg::ST_DIVSET) begin : g_sqrt
            // One result bit per stage: bring in two radicand bits and try
            // to subtract four times the root plus one.
            always_comb begin
                logic [qnl_pkg::SREM_W+1:0] rem2;
                logic [qnl_pkg::SREM_W+1:0] trial;
                stage_next[k] = stage_reg[k-1];
                rem2  = {stage_reg[k-1].srem,
                         stage_reg[k-1].sqv[qnl_pkg::SUM_W-1 -: 2]};
                trial = {2'b00, stage_reg[k-1].root, 2'b01};
                if (rem2 >= trial) begin
                    stage_next[k].srem = qnl_pkg::SREM_W'(rem2 - trial);
                    stage_next[k].root = {stage_reg[k-1].root[qnl_pkg::ROOT_W-2:0], 1'b1};
                end else begin
                    stage_next[k].srem = qnl_pkg::SREM_W'(rem2);
                    stage_next[k].root = {stage_reg[k-1].root[qnl_pkg::ROOT_W-2:0], 1'b0};
                end
                stage_next[k].sqv = {stage_reg[k-1].sqv[qnl_pkg::SUM_W-3:0], 2'b00};
            end
        end else if (k == qnl_pkg::ST_DIVSET) begin : g_divset
            // |l| never exceeds the root, so |l| * 2^14 / root fits in the
            // quotient and the top part of the dividend starts below it.
            always_comb begin
                logic [qnl_pkg::BLEND_W-1:0] mag;
                stage_next[k] = stage_reg[k-1];
                for (int i = 0; i < L; i++) begin
                    stage_next[k].neg[i] = stage_reg[k-1].l[i][qnl_pkg::BLEND_W-1];
                    mag = stage_next[k].neg[i] ? -stage_reg[k-1].l[i]
                                               : stage_reg[k-1].l[i];
                    stage_next[k].drem[i] = qnl_pkg::ROOT_W'(mag[qnl_pkg::MAG_W-1:2]);
                    stage_next[k].dlow[i] = {mag[1:0], {qnl_pkg::FRAC_BITS{1'b0}}};
                    stage_next[k].quo[i]  = '0;
                end
            end
        end else if (k < qnl_pkg::ST_OUT) begin : g_div
            always_comb begin
                logic [qnl_pkg::ROOT_W:0] rem2;
                logic [qnl_pkg::ROOT_W:0] dvs;
                stage_next[k] = stage_reg[k-1];
                dvs = {1'b0, stage_reg[k-1].root};
                for (int i = 0; i < L; i++) begin
                    rem2 = {stage_reg[k-1].drem[i],
                            stage_reg[k-1].dlow[i][qnl_pkg::QUO_W-1]};
                    stage_next[k].dlow[i] = {stage_reg[k-1].dlow[i][qnl_pkg::QUO_W-2:0], 1'b0};
                    if (rem2 >= dvs) begin
                        stage_next[k].drem[i] = qnl_pkg::ROOT_W'(rem2 - dvs);
                        stage_next[k].quo[i]  = {stage_reg[k-1].quo[i][qnl_pkg::QUO_W-2:0], 1'b1};
                    end else begin
                        stage_next[k].drem[i] = qnl_pkg::ROOT_W'(rem2);
                        stage_next[k].quo[i]  = {stage_reg[k-1].quo[i][qnl_pkg::QUO_W-2:0], 1'b0};
                    end
                end
            end
        end else begin : g_out
            always_comb begin
                logic signed [16:0] sv;
                stage_next[k]    = stage_reg[k-1];
                stage_next[k].zn = (stage_reg[k-1].root == '0);
                for (int i = 0; i < L; i++) begin
                    sv = $signed({1'b0, stage_reg[k-1].quo[i]});
                    if (stage_reg[k-1].neg[i]) begin
                        sv = -sv;
                    end
                    if (stage_next[k].zn) begin
                        stage_next[k].r[i] = '0;
                    end else if (sv > 17'sd32767) begin
                        stage_next[k].r[i] = 16'h7fff;
                    end else if (sv < -17'sd32768) begin
                        stage_next[k].r[i] = 16'h8000;
                    end else begin
                        stage_next[k].r[i] = sv[15:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (adv[0]) begin
                valid_reg[0] <= s_valid;
            end
            for (int k = 1; k < N; k++) begin
                if (adv[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < N; k++) begin
            if (adv[k]) begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    assign m_valid     = valid_reg[N-1];
    assign m_r_w       = stage_reg[N-1].r[0];
    assign m_r_x       = stage_reg[N-1].r[1];
    assign m_r_y       = stage_reg[N-1].r[2];
    assign m_r_z       = stage_reg[N-1].r[3];
    assign m_zero_norm = stage_reg[N-1].zn;

endmodule

FILE: rtl/core/qnl_checker.sv
// ----------------------------------------------------------------------------
// qnl_checker
// Port-level checks on the quaternion nlerp result channel.
// ----------------------------------------------------------------------------
module qnl_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_r_w,
    input logic [15:0] m_r_x,
    input logic [15:0] m_r_y,
    input logic [15:0] m_r_z,
    input logic        m_zero_norm
);

    // A stalled result beat keeps its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_r_w) && $stable(m_r_x)
            && $stable(m_r_y) && $stable(m_r_z) && $stable(m_zero_norm))
        else $error("result beat changed while stalled");

    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_zero_norm |-> m_r_w == 16'h0 && m_r_x == 16'h0
            && m_r_y == 16'h0 && m_r_z == 16'h0)
        else $error("zero-length result has nonzero components");

    // No component can exceed the unit length, 16384 in Q2.14.
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $signed(m_r_w) <= 16384 && $signed(m_r_w) >= -16384
            && $signed(m_r_x) <= 16384 && $signed(m_r_x) >= -16384
            && $signed(m_r_y) <= 16384 && $signed(m_r_y) >= -16384
            && $signed(m_r_z) <= 16384 && $signed(m_r_z) >= -16384)
        else $error("result component beyond unit length");

endmodule

bind quaternion_nlerp qnl_checker u_qnl_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_r_w       (m_r_w),
    .m_r_x       (m_r_x),
    .m_r_y       (m_r_y),
    .m_r_z       (m_r_z),
    .m_zero_norm (m_zero_norm)
);

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for quaternion_nlerp: a directed table followed by
// random quaternion pairs, each result checked against a behavioral predictor
// of the blend, shortest-path flip, square root and normalization.
// ----------------------------------------------------------------------------
module tb;

    typedef struct {
        logic [15:0] p [4];
        logic [15:0] q [4];
        logic [15:0] t;
    } pair_t;

    typedef struct {
        logic [15:0] r [4];
        logic        zn;
    } unit_t;

    typedef struct {
        pair_t  in;
        logic   known;
        unit_t  res;
    } row_t;

    localparam int LATENCY = 44;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_shortest_path = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [15:0] s_p_w = '0, s_p_x = '0, s_p_y = '0, s_p_z = '0;
    logic [15:0] s_q_w = '0, s_q_x = '0, s_q_y = '0, s_q_z = '0;
    logic [15:0] s_blend = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_r_w, m_r_x, m_r_y, m_r_z;
    logic        m_zero_norm;

    logic        flip_on;
    unit_t       pending_units [$];
    int          fail_count = 0;
    int          result_count = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    logic        recv_hold = 1'b0;
    int          flips_seen = 0;
    int          zero_seen = 0;

    quaternion_nlerp DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_shortest_path(cfg_shortest_path),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_p_w(s_p_w), .s_p_x(s_p_x), .s_p_y(s_p_y), .s_p_z(s_p_z),
        .s_q_w(s_q_w), .s_q_x(s_q_x), .s_q_y(s_q_y), .s_q_z(s_q_z),
        .s_blend(s_blend),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_r_w(m_r_w), .m_r_x(m_r_x), .m_r_y(m_r_y), .m_r_z(m_r_z),
        .m_zero_norm(m_zero_norm)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic longint isqrt_floor(longint unsigned v);
        longint unsigned root = 0;
        longint unsigned bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(root);
    endfunction

    function automatic unit_t nlerp_predict(pair_t a, logic flip);
        unit_t u;
        longint pv [4], qv [4], lv [4];
        longint dot, prod, root, quo;
        longint unsigned sumsq;
        dot = 0;
        sumsq = 0;
        for (int i = 0; i < 4; i++) begin
            pv[i] = longint'($signed(a.p[i]));
            qv[i] = longint'($signed(a.q[i]));
            dot += pv[i] * qv[i];
        end
        if (flip && dot < 0) begin
            for (int i = 0; i < 4; i++) qv[i] = -qv[i];
        end
        for (int i = 0; i < 4; i++) begin
            prod = longint'(a.t) * (qv[i] - pv[i]);
            // Floor division by 2^15; arithmetic shift floors for negatives.
            lv[i] = pv[i] + (prod >>> 15);
            sumsq += longint'(lv[i] * lv[i]);
        end
        root = isqrt_floor(sumsq);
        u.zn = (root == 0);
        for (int i = 0; i < 4; i++) begin
            if (root == 0) begin
                u.r[i] = '0;
            end else begin
                quo = (lv[i] * 16384) / root;
                if (quo > 32767) quo = 32767;
                if (quo < -32768) quo = -32768;
                u.r[i] = quo[15:0];
            end
        end
        return u;
    endfunction

    function automatic pair_t make_pair(int pw, int px, int py, int pz,
                                        int qw, int qx, int qy, int qz, int t);
        pair_t a;
        a.p = '{pw[15:0], px[15:0], py[15:0], pz[15:0]};
        a.q = '{qw[15:0], qx[15:0], qy[15:0], qz[15:0]};
        a.t = t[15:0];
        return a;
    endfunction

    function automatic unit_t make_unit(int w, int x, int y, int z, logic zn);
        unit_t u;
        u.r = '{w[15:0], x[15:0], y[15:0], z[15:0]};
        u.zn = zn;
        return u;
    endfunction

    task automatic write_flip(logic value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_shortest_path <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        flip_on = value;
    endtask

    task automatic send_pair(pair_t a, logic known, unit_t want);
        unit_t guess;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        guess = nlerp_predict(a, flip_on);
        if (known) begin
            for (int i = 0; i < 4; i++) begin
                if (guess.r[i] !== want.r[i]) begin
                    $error("table row r[%0d] exp %0h got %0h from predictor",
                           i, want.r[i], guess.r[i]);
                    fail_count++;
                end
            end
            if (guess.zn !== want.zn) begin
                $error("table row zero_norm exp %0b got %0b from predictor",
                       want.zn, guess.zn);
                fail_count++;
            end
        end
        if (guess.zn) zero_seen++;
        s_valid <= 1'b1;
        {s_p_w, s_p_x, s_p_y, s_p_z} <= {a.p[0], a.p[1], a.p[2], a.p[3]};
        {s_q_w, s_q_x, s_q_y, s_q_z} <= {a.q[0], a.q[1], a.q[2], a.q[3]};
        s_blend <= a.t;
        do @(posedge aclk); while (!s_ready);
        pending_units.push_back(known ? want : guess);
    endtask

    task automatic drain_units();
        s_valid <= 1'b0;
        while (pending_units.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(64)) - 16'd32;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic pair_t rand_pair();
        pair_t a;
        for (int i = 0; i < 4; i++) begin
            a.p[i] = rand_comp();
            a.q[i] = ($urandom_range(7) == 0) ? a.p[i] : rand_comp();
        end
        case ($urandom_range(7))
            0: a.t = 16'd0;
            1: a.t = 16'd32768;
            2: a.t = 16'($urandom_range(65535, 32769));
            default: a.t = 16'($urandom_range(32768));
        endcase
        return a;
    endfunction

    // Receiver: random stalls, plus a long hold-off when asked.
    always @(posedge aclk) begin
        if (!aresetn || recv_hold)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        unit_t want;
        if (aresetn && m_valid && m_ready) begin
            result_count++;
            if (pending_units.size() == 0) begin
                $error("result beat with no expectation pending");
                fail_count++;
            end else begin
                want = pending_units.pop_front();
                if (m_r_w !== want.r[0]) begin
                    $error("r_w exp %0h got %0h", want.r[0], m_r_w); fail_count++;
                end
                if (m_r_x !== want.r[1]) begin
                    $error("r_x exp %0h got %0h", want.r[1], m_r_x); fail_count++;
                end
                if (m_r_y !== want.r[2]) begin
                    $error("r_y exp %0h got %0h", want.r[2], m_r_y); fail_count++;
                end
                if (m_r_z !== want.r[3]) begin
                    $error("r_z exp %0h got %0h", want.r[3], m_r_z); fail_count++;
                end
                if (m_zero_norm !== want.zn) begin
                    $error("zero_norm exp %0b got %0b", want.zn, m_zero_norm);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #4000000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        row_t table_rows [$];
        row_t row;
        pair_t a;
        flip_on = 1'b1;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed rows; those with a typed result are obvious by inspection.
        row.known = 1'b1;
        row.in = make_pair(16384, 0, 0, 0, 16384, 0, 0, 0, 0);
        row.res = make_unit(16384, 0, 0, 0, 0); table_rows.push_back(row);
        row.in = make_pair(0, 0, 0, 0, 0, 0, 0, 0, 16384);
        row.res = make_unit(0, 0, 0, 0, 1); table_rows.push_back(row);
        row.in = make_pair(0, 16384, 0, 0, 0, 0, 16384, 0, 32768);
        row.res = make_unit(0, 0, 16384, 0, 0); table_rows.push_back(row);
        row.in = make_pair(16384, 0, 0, 0, -16384, 0, 0, 0, 16384);
        row.res = make_unit(16384, 0, 0, 0, 0); table_rows.push_back(row);
        row.in = make_pair(0, 0, 0, 1, 0, 0, 0, 1, 0);
        row.res = make_unit(0, 0, 0, 16384, 0); table_rows.push_back(row);
        row.known = 1'b0;
        row.in = make_pair(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767, 0);
        table_rows.push_back(row);
        row.in = make_pair(32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768,
                           32768);
        table_rows.push_back(row);
        row.in = make_pair(16384, 0, 0, 0, 0, 16384, 0, 0, 65535);
        table_rows.push_back(row);
        row.in = make_pair(100, -200, 300, -400, 50, 60, 70, 80, 32769);
        table_rows.push_back(row);
        row.in = make_pair(1, 0, 0, 0, 0, 1, 0, 0, 16384);
        table_rows.push_back(row);
        row.in = make_pair(3, 0, 0, 0, -3, 0, 0, 0, 16384);
        table_rows.push_back(row);
        row.in = make_pair(-32768, 0, 0, 0, 1, 0, 0, 0, 1);
        table_rows.push_back(row);

        foreach (table_rows[k]) send_pair(table_rows[k].in, table_rows[k].known,
                                          table_rows[k].res);
        drain_units();
        write_flip(1'b0);
        // With the flip off, opposite quaternions at the midpoint cancel out.
        send_pair(make_pair(16384, 0, 0, 0, -16384, 0, 0, 0, 16384), 1'b1,
                  make_unit(0, 0, 0, 0, 1));
        foreach (table_rows[k]) send_pair(table_rows[k].in, 1'b0, row.res);
        drain_units();
        write_flip(1'b1);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 59 : 0;
            recv_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 19 : 0;
            for (int n = 0; n < 330; n++) begin
                a = rand_pair();
                if (phase == 2 && n == 100) begin
                    recv_hold = 1'b1;
                    fork
                        begin
                            repeat (300) @(posedge aclk);
                            recv_hold = 1'b0;
                        end
                    join_none
                end
                send_pair(a, 1'b0, row.res);
            end
            // Sender pauses here until the pipeline has emptied.
            drain_units();
            write_flip(phase != 0);
            flips_seen++;
        end

        drain_units();
        $display("Covered %0d results, %0d zero-length blends, %0d flip-mode changes.",
                 result_count, zero_seen, flips_seen + 2);
        if (fail_count == 0 && pending_units.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
